FILE: sv/efr_pkg.sv
`default_nettype none

package efr_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_BYTE    = 3'd0,
    REG_END_BYTE      = 3'd1,
    REG_ESCAPE_BYTE   = 3'd2,
    REG_ESC_END_CODE  = 3'd3,
    REG_ESC_ESC_CODE  = 3'd4,
    REG_MAX_FRAME     = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] START_BYTE_RST   = 8'd192;
  localparam logic [7:0] END_BYTE_RST     = 8'd192;
  localparam logic [7:0] ESCAPE_BYTE_RST  = 8'd219;
  localparam logic [7:0] ESC_END_CODE_RST = 8'd220;
  localparam logic [7:0] ESC_ESC_CODE_RST = 8'd221;
  localparam logic [7:0] MAX_FRAME_RST    = 8'd64;

  localparam logic [7:0] CHK_INVERT       = 8'hFF;
  localparam logic [7:0] LEN_MAX          = 8'hFF;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [7:0] byte_position;
    logic       checksum_ok;
    logic [7:0] frame_length;
    logic       restarted;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/escaped_frame_receiver_unit.sv
`default_nettype none

// Escaped frame receiver: takes one raw link byte per word on the input
// channel, undoes byte stuffing and gives at most one result word per byte,
// either a stored byte with its position or a frame-complete word with the
// length and the sum checksum verdict. Each byte is handled by the logic in
// front of the result register, so one byte is taken per clock as long as
// the result register is empty or being read in the same cycle; an output
// stall holds off the input. Configuration registers are written through the
// plain write port; the user must write them only while the block is idle, as the block itself does not enforce this.
module escaped_frame_receiver_unit
  import efr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,

  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,

  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      byte_value_o,
  output logic [7:0]      byte_position_o,
  output logic            checksum_ok_o,
  output logic [7:0]      frame_length_o,
  output logic            restarted_o
);

  logic [7:0] start_byte_q, end_byte_q, escape_byte_q;
  logic [7:0] esc_end_code_q, esc_esc_code_q, max_frame_q;

  logic [7:0] count_q, count_d;
  logic       esc_pend_q, esc_pend_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] last_q, last_d;

  logic       out_valid_q;
  result_t    res_q, res_d;
  logic       has_res;
  logic       accept;

  logic [7:0] ubyte;
  logic [7:0] pos;
  logic       restart;
  logic [7:0] part_sum;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q   <= START_BYTE_RST;
      end_byte_q     <= END_BYTE_RST;
      escape_byte_q  <= ESCAPE_BYTE_RST;
      esc_end_code_q <= ESC_END_CODE_RST;
      esc_esc_code_q <= ESC_ESC_CODE_RST;
      max_frame_q    <= MAX_FRAME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_BYTE:   start_byte_q   <= cfg_data_i;
        REG_END_BYTE:     end_byte_q     <= cfg_data_i;
        REG_ESCAPE_BYTE:  escape_byte_q  <= cfg_data_i;
        REG_ESC_END_CODE: esc_end_code_q <= cfg_data_i;
        REG_ESC_ESC_CODE: esc_esc_code_q <= cfg_data_i;
        REG_MAX_FRAME:    max_frame_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-byte decode.
  always_comb begin
    count_d  = count_q;
    esc_pend_d = esc_pend_q;
    sum_d    = sum_q;
    last_d   = last_q;
    res_d    = '0;
    has_res  = 1'b0;

    if (esc_pend_q && rx_byte_i == esc_end_code_q) begin
      ubyte = end_byte_q;
    end else if (esc_pend_q && rx_byte_i == esc_esc_code_q) begin
      ubyte = escape_byte_q;
    end else begin
      ubyte = rx_byte_i;
    end
    restart  = (count_q >= max_frame_q);
    pos      = restart ? 8'd0 : count_q;
    part_sum = sum_q - last_q;

    if (count_q == 8'd0 && rx_byte_i != start_byte_q) begin
      esc_pend_d = 1'b0;
    end else if (rx_byte_i == escape_byte_q) begin
      esc_pend_d = (count_q != 8'd0);
    end else if (count_q > 8'd1 && rx_byte_i == end_byte_q) begin
      // The escape flag deliberately survives a frame close.
      has_res            = 1'b1;
      res_d.kind         = KIND_FRAME;
      res_d.checksum_ok  = ((part_sum ^ CHK_INVERT) == last_q);
      res_d.frame_length = (count_q == LEN_MAX) ? LEN_MAX : count_q + 8'd1;
      count_d            = 8'd0;
    end else begin
      esc_pend_d          = 1'b0;
      sum_d               = (pos == 8'd0) ? 8'd0 : sum_q + ubyte;
      last_d              = ubyte;
      count_d             = pos + 8'd1;
      has_res             = 1'b1;
      res_d.kind          = KIND_BYTE;
      res_d.byte_value    = ubyte;
      res_d.byte_position = pos;
      res_d.restarted     = restart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 8'd0;
      esc_pend_q  <= 1'b0;
      sum_q       <= 8'd0;
      last_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q    <= count_d;
        esc_pend_q <= esc_pend_d;
        sum_q      <= sum_d;
        last_q     <= last_d;
      end
      if (accept && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign byte_value_o    = res_q.byte_value;
  assign byte_position_o = res_q.byte_position;
  assign checksum_ok_o   = res_q.checksum_ok;
  assign frame_length_o  = res_q.frame_length;
  assign restarted_o     = res_q.restarted;

endmodule

`default_nettype wire

FILE: sv/efr_checker.sv
`default_nettype none

module efr_checker
  import efr_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       kind_o,
  input wire logic [7:0] byte_value_o,
  input wire logic [7:0] byte_position_o,
  input wire logic       checksum_ok_o,
  input wire logic [7:0] frame_length_o,
  input wire logic       restarted_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(byte_value_o) && $stable(byte_position_o)
      && $stable(kind_o) && $stable(frame_length_o))
    else $error("stalled result word changed");

  // A held result register must block new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result register is full");

  // A completed frame holds at least two bytes plus the end byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FRAME |-> frame_length_o >= 8'd3
      && byte_value_o == 8'd0 && byte_position_o == 8'd0 && !restarted_o)
    else $error("malformed frame-complete word");

  // A restarted byte always lands at the head of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BYTE |-> !checksum_ok_o && frame_length_o == 8'd0
      && (!restarted_o || byte_position_o == 8'd0))
    else $error("malformed stored-byte word");

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (.*);

`default_nettype wire
